@@ rtl/core/dsde_pkg.sv @@
// Package for the DVD sector descrambler and EDC checker.
// Holds the transaction structs, the sector layout constants and the byte-wide
// scrambler and EDC step functions. No dependencies.
package dsde_pkg;

	localparam int RAW_SECTOR_BYTES = 2064;
	localparam int EDC_SPAN_BYTES   = 2060;
	localparam int PAYLOAD_BYTES    = 2048;
	localparam int SCRAMBLE_FIRST   = 12;
	localparam int PAYLOAD_FIRST    = 6;

	localparam int POS_W  = 12;
	localparam int IDX_W  = 11;
	localparam int LFSR_W = 15;
	localparam int EDC_W  = 32;

	localparam logic [EDC_W-1:0] EDC_POLY = 32'h8000_0011;
	localparam logic [EDC_W-1:0] EDC_INIT = 32'h0000_0000;

	localparam logic [POS_W-1:0] POS_SCR_FIRST = POS_W'(SCRAMBLE_FIRST);
	localparam logic [POS_W-1:0] POS_EDC_END   = POS_W'(EDC_SPAN_BYTES);
	localparam logic [POS_W-1:0] POS_PAY_FIRST = POS_W'(PAYLOAD_FIRST);
	localparam logic [POS_W-1:0] POS_PAY_END   = POS_W'(PAYLOAD_FIRST + PAYLOAD_BYTES);
	localparam logic [POS_W-1:0] POS_LAST      = POS_W'(RAW_SECTOR_BYTES - 1);
	localparam logic [POS_W-1:0] POS_END       = POS_W'(RAW_SECTOR_BYTES);

	typedef struct packed {
		logic [7:0]        raw_byte;
		logic              sector_start;
		logic [LFSR_W-1:0] seed;
	} raw_in_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [IDX_W-1:0] byte_index;
		logic             verdict_item;
		logic             edc_ok;
	} res_t;

	typedef struct packed {
		logic [7:0]        key;
		logic [LFSR_W-1:0] lfsr;
	} scr_t;

	// eight LFSR ticks, key byte MSB first
	function automatic scr_t scramble_byte(input logic [LFSR_W-1:0] s);
		scr_t r;
		logic [LFSR_W-1:0] st;
		logic [7:0] k;
		logic top;
		st = s;
		k = '0;
		for (int i = 0; i < 8; i++) begin
			top = st[14];
			st = {st[13:0], top ^ st[10]};
			k = {k[6:0], top};
		end
		r.key = k;
		r.lfsr = st;
		return r;
	endfunction

	function automatic logic [EDC_W-1:0] edc_byte(input logic [EDC_W-1:0] crc,
			input logic [7:0] b);
		logic [EDC_W-1:0] c;
		c = crc ^ {b, 24'h0};
		for (int i = 0; i < 8; i++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ EDC_POLY;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/dsde_sector.sv @@
// Per-sector state (LFSR, EDC accumulator, position, stored EDC bytes) and the
// one-byte descramble / EDC / result logic. Depends on dsde_pkg.
module dsde_sector (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  dsde_pkg::raw_in_t item,
	output logic              hit,
	output dsde_pkg::res_t    res
);

	logic [dsde_pkg::POS_W-1:0]  pos_q;
	logic [dsde_pkg::LFSR_W-1:0] lfsr_q;
	logic [dsde_pkg::EDC_W-1:0]  crc_q;
	logic [23:0]                 sedc_q;

	logic [dsde_pkg::POS_W-1:0]  pos;
	logic [dsde_pkg::LFSR_W-1:0] lfsr_cur;
	logic [dsde_pkg::EDC_W-1:0]  crc_cur;
	logic [dsde_pkg::EDC_W-1:0]  crc_nx;
	logic [23:0]                 sedc_cur;
	dsde_pkg::scr_t              scr;
	logic [7:0]                  b;
	logic                        live, in_scr, in_edc, is_last, payload;

	always_comb begin
		pos      = item.sector_start ? '0 : pos_q;
		lfsr_cur = item.sector_start ? item.seed : lfsr_q;
		crc_cur  = item.sector_start ? dsde_pkg::EDC_INIT : crc_q;
		sedc_cur = item.sector_start ? '0 : sedc_q;

		live    = pos < dsde_pkg::POS_END;
		in_scr  = (pos >= dsde_pkg::POS_SCR_FIRST) && (pos < dsde_pkg::POS_EDC_END);
		in_edc  = pos < dsde_pkg::POS_EDC_END;
		is_last = pos == dsde_pkg::POS_LAST;
		payload = (pos >= dsde_pkg::POS_PAY_FIRST) && (pos < dsde_pkg::POS_PAY_END);

		scr    = dsde_pkg::scramble_byte(lfsr_cur);
		b      = in_scr ? (item.raw_byte ^ scr.key) : item.raw_byte;
		crc_nx = dsde_pkg::edc_byte(crc_cur, b);

		hit = live && (payload || is_last);
		if (payload) begin
			res.out_byte     = b;
			res.byte_index   = dsde_pkg::IDX_W'(pos - dsde_pkg::POS_PAY_FIRST);
			res.verdict_item = 1'b0;
			res.edc_ok       = 1'b0;
		end else begin
			res.out_byte     = '0;
			res.byte_index   = '0;
			res.verdict_item = 1'b1;
			res.edc_ok       = ({sedc_cur, b} == crc_cur);
		end
	end

	// past the sector end nothing moves until the next start flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			lfsr_q <= '0;
			crc_q  <= '0;
			sedc_q <= '0;
		end else if (advance && live) begin
			pos_q  <= pos + dsde_pkg::POS_W'(1);
			lfsr_q <= in_scr ? scr.lfsr : lfsr_cur;
			crc_q  <= in_edc ? crc_nx : crc_cur;
			sedc_q <= (!in_edc && !is_last) ? {sedc_cur[15:0], b} : sedc_cur;
		end
	end

endmodule

@@ rtl/core/dsde_out_reg.sv @@
// Result register of the descrambler: holds one result transaction while the
// receiver stalls and reports whether it can take the next one. Uses dsde_pkg.
module dsde_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic           hit,
	input  dsde_pkg::res_t res,
	input  logic           res_stall,
	output logic           res_valid,
	output dsde_pkg::res_t res_data,
	output logic           ready
);

	logic           valid_q;
	dsde_pkg::res_t data_q;

	assign ready     = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load && hit) begin
			data_q <= res;
		end
	end

endmodule

@@ rtl/core/dvd_sector_descramble_edc_check.sv @@
// DVD sector descrambler with EDC check.
// Input channel raw_valid / raw_stall / raw carries one raw sector byte per
// transaction; sector_start marks byte 0 and the seed is sampled with it.
// Output channel res_valid / res_stall / res_data carries the 2048 descrambled
// payload bytes (raw bytes 6 to 2053, byte_index 0 to 2047), then one verdict
// transaction at raw byte 2063 with edc_ok set if the 32-bit EDC CRC over bytes 0 to
// 2059 matches the stored EDC. Other bytes give no result; bytes after 2063
// are dropped until the next sector_start.
// Path: a byte is held in two registers on its way to a result: the accepting
// edge fills the input register, and from there it passes into the result
// register. Throughput: one byte per cycle while res_stall is low; the LFSR and
// CRC byte steps are combinational logic between the two registers.
// Stall: while res_stall holds a pending result, the input register can still
// fill, then raw_stall rises; nothing is lost.
// Reset: arst_n clears both registers' valid flags and the sector state, which
// behaves as a sector begun with seed zero if no start flag arrives.
module dvd_sector_descramble_edc_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              raw_valid,
	output logic              raw_stall,
	input  dsde_pkg::raw_in_t raw,
	output logic              res_valid,
	input  logic              res_stall,
	output dsde_pkg::res_t    res_data
);

	logic              valid_s1;
	dsde_pkg::raw_in_t item_s1;
	logic              ready, advance, hit;
	dsde_pkg::res_t    res;

	assign advance   = valid_s1 && ready;
	assign raw_stall = valid_s1 && !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw_valid && !raw_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (raw_valid && !raw_stall) begin
			item_s1 <= raw;
		end
	end

	dsde_sector u_sector (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.hit     (hit),
		.res     (res)
	);

	dsde_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.hit       (hit),
		.res       (res),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_data  (res_data),
		.ready     (ready)
	);

endmodule

@@ rtl/core/dsde_checker.sv @@
// Port-level checks for the descrambler top level, bound to it below.
// Depends on dsde_pkg and dvd_sector_descramble_edc_check.
module dsde_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              raw_valid,
	input logic              raw_stall,
	input dsde_pkg::raw_in_t raw,
	input logic              res_valid,
	input logic              res_stall,
	input dsde_pkg::res_t    res_data
);

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result transaction changed");

	// an empty result register never backs up the input side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !raw_stall)
		else $error("input stalled with empty result register");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.verdict_item |->
			res_data.out_byte == 8'h00 && res_data.byte_index == '0)
		else $error("verdict transaction carries payload bits");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.verdict_item |-> !res_data.edc_ok)
		else $error("payload transaction carries edc_ok");

endmodule

bind dvd_sector_descramble_edc_check dsde_checker u_dsde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.raw_valid (raw_valid),
	.raw_stall (raw_stall),
	.raw       (raw),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
